// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/piccolo_pkg.sv =====
// ----------------------------------------------------------------------------
// Piccolo package
// Shared constants, types and round functions of the Piccolo encryptor.
// ----------------------------------------------------------------------------
`default_nettype none
package piccolo_pkg;

  localparam int unsigned Rounds80  = 25;
  localparam int unsigned Rounds128 = 31;
  localparam int unsigned NumCells  = Rounds128;
  localparam int unsigned CellIdxW  = $clog2(NumCells + 1);
  localparam logic [31:0] Con80Mask  = 32'h0f1e2d3c;
  localparam logic [31:0] Con128Mask = 32'h6547a98b;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1,
    CfgKeySize = 2'd2,
    CfgUnused  = 2'd3
  } cfg_idx_e;

  // Data carried from one round cell to the next.
  typedef struct packed {
    logic        valid;
    logic [63:0] blk;
  } cell_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'he;  4'h1: r = 4'h4;  4'h2: r = 4'hb;  4'h3: r = 4'h2;
      4'h4: r = 4'h3;  4'h5: r = 4'h8;  4'h6: r = 4'h0;  4'h7: r = 4'h9;
      4'h8: r = 4'h1;  4'h9: r = 4'ha;  4'ha: r = 4'h7;  4'hb: r = 4'hf;
      4'hc: r = 4'h6;  4'hd: r = 4'hc;  4'he: r = 4'h5;
      default: r = 4'hd;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] gf_dbl(input logic [3:0] x);
    return {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
  endfunction

  function automatic logic [15:0] f_func(input logic [15:0] x);
    logic [3:0] a0, a1, a2, a3, y0, y1, y2, y3;
    a0 = sbox(x[15:12]);
    a1 = sbox(x[11:8]);
    a2 = sbox(x[7:4]);
    a3 = sbox(x[3:0]);
    y0 = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
    y1 = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
    y2 = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
    y3 = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
    return {sbox(y0), sbox(y1), sbox(y2), sbox(y3)};
  endfunction

  function automatic logic [31:0] con_pair(input logic [4:0] c, input logic [31:0] mask);
    logic [31:0] w;
    w = {27'd0, c};
    return ((w << 27) | (w << 17) | (w << 10) | w) ^ mask;
  endfunction

  function automatic logic [63:0] round_perm(input logic [63:0] x);
    logic [7:0] b [8];
    for (int i = 0; i < 8; i++) begin
      b[i] = x[63 - 8*i -: 8];
    end
    return {b[2], b[7], b[4], b[1], b[6], b[3], b[0], b[5]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/piccolo_if.sv =====
// ----------------------------------------------------------------------------
// Piccolo stream interface
// Valid/ready channel carrying one 64-bit block.
// ----------------------------------------------------------------------------
`default_nettype none
interface piccolo_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/piccolo_block_encrypt.sv =====
// A block passes through the 31 round cells and then the output register.
// Throughput: one block per cycle while the output is not stalled; the chain of 31 round cells advances together.
// In 80-bit mode the last six cells pass the block through unchanged.
// Reset clears all valid bits and key registers to zero; keys are undefined
// in no case. Stall on the output holds the whole chain.
// ----------------------------------------------------------------------------
// Piccolo block encrypt
// Unrolled round pipeline encrypting one 64-bit block per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module piccolo_block_encrypt (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [piccolo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [piccolo_pkg::CfgDataW-1:0] cfg_data_i,
  piccolo_if.sink                               plain_block_i,
  piccolo_if.source                             cipher_block_o
);
  logic               big;
  logic [63:0]        wk;
  logic [31:0]        rk [piccolo_pkg::NumCells];
  piccolo_pkg::cell_t chain [piccolo_pkg::NumCells + 1];
  logic               en;
  logic               out_valid_q;
  logic [63:0]        out_blk_q;
  logic [63:0]        w;

  piccolo_keysched u_ks (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .big_o(big), .wk_o(wk), .rk_o(rk)
  );

  // The chain advances unless a valid result is stuck at the output.
  assign en = !out_valid_q || cipher_block_o.ready;
  assign plain_block_i.ready = en;

  assign chain[0].valid = plain_block_i.valid;
  assign chain[0].blk = plain_block_i.data ^ {wk[63:48], 16'h0, wk[47:32], 16'h0};

  for (genvar g = 0; g < piccolo_pkg::NumCells; g++) begin : g_cell
    logic active, last;
    assign active = big || (g < piccolo_pkg::Rounds80);
    assign last = big ? (g == piccolo_pkg::Rounds128 - 1) :
                        (g == piccolo_pkg::Rounds80 - 1);
    piccolo_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .active_i(active), .last_i(last),
      .rk_i(rk[g]), .in_i(chain[g]), .out_o(chain[g+1])
    );
  end

  assign w = chain[piccolo_pkg::NumCells].blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   out_valid_q <= 1'b0;
    else if (en)   out_valid_q <= chain[piccolo_pkg::NumCells].valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_blk_q <= w ^ {wk[31:16], 16'h0, wk[15:0], 16'h0};
  end

  assign cipher_block_o.valid = out_valid_q;
  assign cipher_block_o.data = out_blk_q;

  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, plain_block_i.ready)
  `ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni,
               cipher_block_o.valid && !cipher_block_o.ready, $stable(out_blk_q))
  `ASSERT_NEXT(a_valid_advances, clk_i, rst_ni,
               en && chain[piccolo_pkg::NumCells].valid, out_valid_q)
endmodule
`default_nettype wire

// ===== rtl/core/piccolo_keysched.sv =====
// ----------------------------------------------------------------------------
// Piccolo key schedule
// Registers the key and derives whitening and all round keys.
// ----------------------------------------------------------------------------
`default_nettype none
module piccolo_keysched (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [piccolo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [piccolo_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                                   big_o,
  output logic [63:0]                            wk_o,
  output logic [31:0]                            rk_o [piccolo_pkg::NumCells]
);
  logic [63:0] key_low_q, key_high_q;
  logic        key_size_q;
  logic [15:0] k [8];
  logic [15:0] rk_big [62];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_size_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (piccolo_pkg::cfg_idx_e'(cfg_idx_i))
        piccolo_pkg::CfgKeyLow:  key_low_q  <= cfg_data_i;
        piccolo_pkg::CfgKeyHigh: key_high_q <= cfg_data_i;
        piccolo_pkg::CfgKeySize: key_size_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      k[i]   = key_low_q[16*i +: 16];
      k[i+4] = key_high_q[16*i +: 16];
    end
  end

  // The 128-bit schedule is static given the key, so it is plain wiring.
  always_comb begin
    logic [15:0] w [8];
    logic [15:0] t [8];
    logic [31:0] c;
    for (int j = 0; j < 8; j++) w[j] = k[j];
    for (int i = 0; i < 62; i++) begin
      c = piccolo_pkg::con_pair(5'((i >> 1) + 1), piccolo_pkg::Con128Mask);
      t[0] = w[2]; t[1] = w[1]; t[2] = w[6]; t[3] = w[7];
      t[4] = w[0]; t[5] = w[3]; t[6] = w[4]; t[7] = w[5];
      if (((i + 2) % 8) == 0) begin
        for (int j = 0; j < 8; j++) w[j] = t[j];
      end
      rk_big[i] = w[(i + 2) % 8] ^ ((i % 2) == 1 ? c[15:0] : c[31:16]);
    end
  end

  always_comb begin
    logic [31:0] c;
    for (int i = 0; i < piccolo_pkg::NumCells; i++) begin
      c = piccolo_pkg::con_pair(5'(i + 1), piccolo_pkg::Con80Mask);
      if (key_size_q) begin
        rk_o[i] = {rk_big[2*i], rk_big[2*i+1]};
      end else begin
        if ((i % 5) == 0 || (i % 5) == 2) rk_o[i] = c ^ {k[2], k[3]};
        else if ((i % 5) == 3)            rk_o[i] = c ^ {k[4], k[4]};
        else                              rk_o[i] = c ^ {k[0], k[1]};
      end
    end
  end

  assign big_o = key_size_q;
  assign wk_o = key_size_q ?
    {k[0][15:8], k[1][7:0], k[1][15:8], k[0][7:0],
     k[4][15:8], k[7][7:0], k[7][15:8], k[4][7:0]} :
    {k[0][15:8], k[1][7:0], k[1][15:8], k[0][7:0],
     k[4][15:8], k[3][7:0], k[3][15:8], k[4][7:0]};
endmodule
`default_nettype wire

// ===== rtl/core/piccolo_cell.sv =====
// ----------------------------------------------------------------------------
// Piccolo round cell
// One registered round, without the permutation in the last round; passes blocks through unchanged past it.
// ----------------------------------------------------------------------------
`default_nettype none
module piccolo_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            active_i,
  input  wire logic                            last_i,
  input  wire logic [31:0]                     rk_i,
  input  wire piccolo_pkg::cell_t              in_i,
  output piccolo_pkg::cell_t                   out_o
);
  logic        valid_q;
  logic [63:0] blk_q, blk_d, r;

  always_comb begin
    r = in_i.blk;
    r[47:32] = r[47:32] ^ piccolo_pkg::f_func(r[63:48]) ^ rk_i[31:16];
    r[15:0]  = r[15:0] ^ piccolo_pkg::f_func(r[31:16]) ^ rk_i[15:0];
    if (!active_i)    blk_d = in_i.blk;
    else if (last_i)  blk_d = r;
    else              blk_d = piccolo_pkg::round_perm(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     valid_q <= 1'b0;
    else if (en_i)   valid_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) blk_q <= blk_d;
  end

  assign out_o = '{valid: valid_q, blk: blk_q};
endmodule
`default_nettype wire
